[rtl/lkr_pkg.sv]
// Shared types, constants and the generator step function for the
// keystream character rotator. No dependencies.
`timescale 1ns / 1ps

package lkr_pkg;

  // Generator and rotation constants
  localparam int unsigned LKR_MULT  = 75;
  localparam int unsigned LKR_MOD   = 65537;
  localparam int unsigned LKR_SPAN  = 96;
  localparam int unsigned LKR_BASE  = 32;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned GEN_W  = 17;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned CFG_AW = 1;

  // Generator value after one step from a key of 1
  localparam logic [GEN_W-1:0] SEED_RST = GEN_W'(LKR_MULT);

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_KEY  = 1'b1;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queued request: character plus the keystream value it uses
  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic [GEN_W-1:0]  gen;
  } lkr_entry_t;

  // One generator step: v*75 reduced mod 65537 by shift-and-subtract
  function automatic logic [GEN_W-1:0] lkr_advance(input logic [GEN_W-1:0] v);
    logic [22:0] prod;
    logic [17:0] diff;
    begin
      prod = 23'(v) * 23'(LKR_MULT);
      diff = {2'b00, prod[15:0]} - {11'b0, prod[22:16]};
      if (diff[17]) begin
        diff = diff + 18'(LKR_MOD);
      end
      return diff[GEN_W-1:0];
    end
  endfunction

endpackage

[rtl/lkr_front.sv]
// Front end: accepts characters, runs the generator and queues each
// character with its keystream value. Depends on lkr_pkg.
`timescale 1ns / 1ps

module lkr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lkr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lkr_pkg::KEY_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [lkr_pkg::CHAR_W-1:0] char_in,
  input  logic                       restart,
  input  logic                       q_full,
  output logic                       q_push,
  output lkr_pkg::lkr_entry_t        q_wdata
);
  import lkr_pkg::*;

  logic [GEN_W-1:0] seed_r, seed_nxt;
  logic [GEN_W-1:0] gen_r, gen_nxt;
  logic [GEN_W-1:0] cur_gen;
  logic             accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Keystream value for this character: restart uses the stepped key
  assign cur_gen = restart ? seed_r : gen_r;

  assign q_push          = accept;
  assign q_wdata.char_in = char_in;
  assign q_wdata.gen     = cur_gen;

  // Key write stores the already stepped seed
  always_comb begin
    seed_nxt = seed_r;
    if (cfg_we && cfg_addr == REG_KEY) begin
      seed_nxt = lkr_advance({1'b0, cfg_wdata});
    end
  end

  // Generator steps once after each accepted character
  always_comb begin
    gen_nxt = gen_r;
    if (accept) begin
      gen_nxt = lkr_advance(cur_gen);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
      gen_r  <= '0;
    end else begin
      seed_r <= seed_nxt;
      gen_r  <= gen_nxt;
    end
  end

endmodule

[rtl/lkr_queue.sv]
// Two-entry queue between front and back ends.
// Depends on lkr_pkg.
`timescale 1ns / 1ps

module lkr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lkr_pkg::lkr_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output lkr_pkg::lkr_entry_t rdata
);
  import lkr_pkg::*;

  lkr_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/lkr_back.sv]
// Back end: rotates each queued character inside the printable band
// and holds the result in the output register. Depends on lkr_pkg.
`timescale 1ns / 1ps

module lkr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lkr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lkr_pkg::KEY_W-1:0]  cfg_wdata,
  input  logic                       q_not_empty,
  input  lkr_pkg::lkr_entry_t        q_rdata,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lkr_pkg::CHAR_W-1:0] char_out
);
  import lkr_pkg::*;

  logic              mode_r, mode_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;

  logic [11:0]       hi;
  logic [22:0]       hi_prod;
  logic [9:0]        hi_quo;
  logic [1:0]        hi_rem;
  logic [6:0]        amount;
  logic [8:0]        enc_sum;
  logic [9:0]        dec_sum;
  logic [8:0]        pos_sum;
  logic [8:0]        red_sum;
  logic [CHAR_W-1:0] rot_char;

  // gen mod 96 = ((gen >> 5) mod 3) * 32 + gen[4:0]; mod 3 by reciprocal
  assign hi      = q_rdata.gen[16:5];
  assign hi_prod = 23'(hi) * 23'd2731;
  assign hi_quo  = hi_prod[22:13];
  assign hi_rem  = 2'(hi - 12'(hi_quo) * 12'd3);
  assign amount  = {hi_rem, q_rdata.gen[4:0]};

  // Shifted sums: code - 32 +/- amount + 96
  assign enc_sum = 9'(q_rdata.char_in) + 9'(amount) + 9'd64;
  assign dec_sum = 10'(q_rdata.char_in) + 10'd64 - 10'(amount);
  assign pos_sum = mode_r ? dec_sum[8:0] : enc_sum;

  // Sum stays below three spans, so two compares reduce it
  always_comb begin
    if (pos_sum >= 9'(2 * LKR_SPAN)) begin
      red_sum = pos_sum - 9'(2 * LKR_SPAN);
    end else if (pos_sum >= 9'(LKR_SPAN)) begin
      red_sum = pos_sum - 9'(LKR_SPAN);
    end else begin
      red_sum = pos_sum;
    end
  end

  // Negative decrypt sum keeps the truncating remainder: sum + 32
  always_comb begin
    if (mode_r && dec_sum[9]) begin
      rot_char = 7'(dec_sum + 10'(LKR_BASE));
    end else begin
      rot_char = 7'(red_sum + 9'(LKR_BASE));
    end
  end

  // Output register loads whenever it is empty or being drained
  assign q_pop = q_not_empty && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      char_nxt      = rot_char;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Mode register
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_we && cfg_addr == REG_MODE) begin
      mode_nxt = cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign char_out   = char_r;

endmodule

[rtl/lehmer_keystream_char_rotator_top.sv]
// Top level of the keystream character rotator: front end, queue, back end.
// Depends on lkr_pkg, lkr_front, lkr_queue and lkr_back.
//
// Usage:
//   The input stream carries one character per request; in_tuser set
//   reloads the generator from the key before that character. Each request
//   gives exactly one rotated character on the output stream, in order.
//   The config port writes mode (index 0) and key (index 1); write it
//   only while no request is in flight.
// Data path and throughput:
//   An accepted character is written into the queue; at the head, it is
//   popped and rotated into the output register when that is empty or
//   being drained. One character per cycle is sustained while out_tready
//   stays high: the generator step is a single constant multiply and
//   reduce in the front end, fed back each cycle.
// Reset:
//   Synchronous, active low. Mode is encrypt, key is 1, the generator is
//   zero and the queue and output register are empty.
// Stall:
//   When out_tready is low the output register holds; the two-entry queue
//   keeps accepting until full, then in_tready drops.
`timescale 1ns / 1ps

module lehmer_keystream_char_rotator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration write port
  input  logic                      cfg_we,
  input  logic [lkr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lkr_pkg::KEY_W-1:0] cfg_wdata,
  // Input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [6:0] char_in, [7] zero
  input  logic                      in_tuser,   // [0] restart
  // Output stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata   // [6:0] char_out, [7] zero
);
  import lkr_pkg::*;

  logic              q_push, q_full, q_pop, q_not_empty;
  lkr_entry_t        q_wdata, q_rdata;
  logic [CHAR_W-1:0] char_out;

  lkr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .char_in   (in_tdata[CHAR_W-1:0]),
    .restart   (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  lkr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  lkr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .char_out    (char_out)
  );

  assign out_tdata = {1'b0, char_out};

endmodule

[verif/lkr_char_checker.sv]
// Scoreboard for the keystream character rotator: watches the config port and both
// streams, models the generator and the rotation, and checks every output character.
// Depends on lkr_pkg for widths, constants and register indexes.
`timescale 1ns / 1ps

module lkr_char_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lkr_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [lkr_pkg::KEY_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [6:0] char_in, [7] zero
  input  logic                        in_tuser,   // [0] restart
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [7:0]                  out_tdata,  // [6:0] char_out, [7] zero
  output int                          fail_count,
  output int                          pending_count
);
  import lkr_pkg::*;

  // Shadow copy of the block's registers and generator
  logic                  cur_mode;
  logic [KEY_W-1:0]      cur_key;
  logic [GEN_W-1:0]      gen_val;
  logic [CHAR_W-1:0]     expected_chars[$];
  int                    errs = 0;

  // v*75 mod 65537, reduced as low half minus high half, wrapped when negative
  function automatic logic [GEN_W-1:0] next_keystream(input logic [GEN_W-1:0] v);
    int unsigned prod;
    int          diff;
    prod = int'(v) * LKR_MULT;
    diff = int'(prod & 32'h0000_FFFF) - int'(prod >> 16);
    if (diff < 0) diff = diff + int'(LKR_MOD);
    return diff[GEN_W-1:0];
  endfunction

  // Rotate within the 96-code printable band; decrypt below 32 keeps the
  // truncating remainder, so a negative sum lands in 1..31
  function automatic logic [CHAR_W-1:0] band_rotate(input logic [CHAR_W-1:0] ch,
                                                    input logic [GEN_W-1:0]  r,
                                                    input logic              dec);
    int shift;
    int sum;
    shift = int'(r % LKR_SPAN);
    if (dec) sum = int'(ch) - int'(LKR_BASE) - shift + int'(LKR_SPAN);
    else     sum = int'(ch) - int'(LKR_BASE) + shift + int'(LKR_SPAN);
    sum = sum % int'(LKR_SPAN) + int'(LKR_BASE);
    return sum[CHAR_W-1:0];
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    logic [CHAR_W-1:0] want;
    if (!rst_n) begin
      cur_mode = 1'b0;
      cur_key  = KEY_W'(1);
      gen_val  = '0;
      expected_chars.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_MODE) cur_mode = cfg_wdata[0];
        else if (cfg_addr == REG_KEY) cur_key = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        // restart reloads from the key and steps once before use
        if (in_tuser) gen_val = next_keystream({1'b0, cur_key});
        expected_chars.push_back(band_rotate(in_tdata[CHAR_W-1:0], gen_val, cur_mode));
        gen_val = next_keystream(gen_val);
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: output 0x%02h with no request outstanding", $time, out_tdata);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== {1'b0, want}) begin
            $display("%0t: char_out mismatch: expected 0x%02h, actual 0x%02h",
                     $time, {1'b0, want}, out_tdata);
            errs++;
          end
        end
      end
    end
    pending_count <= expected_chars.size();
    fail_count    <= errs;
  end

endmodule

[verif/lehmer_keystream_char_rotator_top_tb.sv]
// Testbench top for the keystream character rotator: clock, reset, stimulus and verdict.
// Depends on lkr_pkg, the rotator RTL and lkr_char_checker.
`timescale 1ns / 1ps

module lehmer_keystream_char_rotator_top_tb;
  import lkr_pkg::*;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr   = '0;
  logic [KEY_W-1:0]   cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = '0;   // [6:0] char_in, [7] zero
  logic               in_tuser   = 1'b0; // [0] restart
  logic               out_tvalid;
  logic               out_tready = 1'b1;
  logic [7:0]         out_tdata;         // [6:0] char_out, [7] zero

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;

  // Idling phases: none, sender only, receiver only, both
  int idle_by_phase[4]  = '{0, 77, 0, 14};
  int stall_by_phase[4] = '{0, 0, 77, 14};

  lehmer_keystream_char_rotator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lkr_char_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // One config write, then a pause with cfg_we low
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [KEY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mode write carries random upper bits, which the block must drop
  task automatic set_cipher(input logic dec, input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] wd;
    wd    = KEY_W'($urandom);
    wd[0] = dec;
    write_reg(REG_MODE, wd);
    write_reg(REG_KEY, k);
  endtask

  // Stop sending and wait until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Send one request, with random idle cycles ahead of it
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic rs);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(127));
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, ch};
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly printable text, sometimes any 7-bit code
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(99) < 85) return CHAR_W'($urandom_range(127, 32));
    return CHAR_W'($urandom_range(127));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return KEY_W'(1);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no restart yet, so the generator sits at zero
    send_char(7'd0, 1'b0);
    send_char(7'd127, 1'b0);
    send_char(7'd31, 1'b0);
    // restart from the reset key, then encrypt of low and high codes
    send_char(7'd65, 1'b1);
    send_char(7'd0, 1'b0);
    send_char(7'd31, 1'b0);
    send_char(7'd126, 1'b0);
    wait_drained();

    // Decrypt with the largest key; codes below 32 can go negative
    set_cipher(1'b1, '1);
    send_char(7'd0, 1'b1);
    send_char(7'd0, 1'b0);
    send_char(7'd31, 1'b0);
    send_char(7'd127, 1'b0);
    send_char(7'd32, 1'b0);
    send_char(7'd1, 1'b1);
    wait_drained();

    // Zero key holds the generator at zero, both modes
    set_cipher(1'b0, '0);
    send_char(7'd5, 1'b1);
    send_char(7'd127, 1'b0);
    wait_drained();
    set_cipher(1'b1, '0);
    send_char(7'd0, 1'b1);
    send_char(7'd96, 1'b0);
    wait_drained();

    // Random part: eight settings, two per idling phase
    for (int s = 0; s < 8; s++) begin
      idle_pct  = idle_by_phase[s / 2];
      stall_pct = stall_by_phase[s / 2];
      set_cipher(s[0], pick_key());
      for (int i = 0; i < 250; i++) begin
        // hold off once until the pipeline is empty
        if (s == 1 && i == 125) wait_drained();
        send_char(pick_char(), (i == 0) || ($urandom_range(99) < 5));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
